[rtl/fsp2_pkg.sv]
package fsp2_pkg;

  localparam int unsigned ValueWidth = 32;
  localparam int unsigned PowerWidth = 16;
  localparam int unsigned FracWidth  = 23;
  localparam int unsigned ExpWidth   = 8;
  // Wide enough for exponent plus power plus margin
  localparam int unsigned EWidth     = 18;

  localparam logic [ExpWidth-1:0]  ExpMax    = 8'hFF;
  localparam logic [31:0]          InfBits   = 32'h7F80_0000;
  localparam logic [FracWidth:0]   HiddenBit = 24'h80_0000;

  typedef struct packed {
    logic [ValueWidth-1:0]        value_bits;
    logic signed [PowerWidth-1:0] power;
  } op_t;

  typedef struct packed {
    logic [ValueWidth-1:0] result_bits;
    logic                  range_error;
  } res_t;

endpackage

[rtl/fsp2_op_if.sv]
interface fsp2_op_if;
  import fsp2_pkg::*;
  logic valid;
  logic ready;
  op_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/fsp2_res_if.sv]
interface fsp2_res_if;
  import fsp2_pkg::*;
  logic valid;
  logic ready;
  res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/fsp2_core.sv]
module fsp2_core (
  input  fsp2_pkg::op_t  op_i,
  output fsp2_pkg::res_t res_o
);
  import fsp2_pkg::*;

  logic                    sign;
  logic [ExpWidth-1:0]     ex;
  logic [FracWidth-1:0]    frac;
  logic [FracWidth:0]      sig;
  logic [4:0]              lz;
  logic signed [EWidth-1:0] e;
  logic signed [EWidth-1:0] p_ext;
  logic                    under;
  logic [5:0]              sh;
  logic [FracWidth:0]      q;
  logic [FracWidth:0]      rem;
  logic [FracWidth:0]      half;
  logic [FracWidth:0]      mask;
  logic [FracWidth:0]      qr;

  // Count leading zeros of a subnormal fraction
  always_comb begin
    lz = 5'd0;
    for (int i = FracWidth - 1; i >= 0; i--) begin
      if (frac[i] && lz == 5'd0 && (frac >> (i + 1)) == '0) begin
        lz = 5'(FracWidth - i);
      end
    end
  end

  assign sign  = op_i.value_bits[31];
  assign ex    = op_i.value_bits[30:23];
  assign frac  = op_i.value_bits[FracWidth-1:0];
  assign p_ext = EWidth'(op_i.power);

  // Normalize and form biased-plus-power exponent
  always_comb begin
    if (ex != '0) begin
      sig   = {1'b1, frac};
      e     = EWidth'(signed'({1'b0, ex})) + p_ext;
      under = (e < -EWidth'(23));
    end else begin
      sig   = {1'b0, frac} << lz;
      e     = EWidth'(1) - EWidth'(lz) + p_ext;
      under = (p_ext < -EWidth'(23));
    end
  end

  // Shift into the subnormal range with round to nearest even
  always_comb begin
    sh   = 6'd0;
    q    = '0;
    rem  = '0;
    half = '0;
    mask = '0;
    qr   = '0;
    if (e < EWidth'(1) && e > -EWidth'(30)) begin
      sh   = 6'(EWidth'(1) - e);
      q    = sig >> sh;
      mask = (sh >= 6'd24) ? '1 : ((24'd1 << sh) - 24'd1);
      rem  = sig & mask;
      half = (sh >= 6'd25) ? '0 : (24'd1 << (sh - 6'd1));
      qr   = q;
      if (sh < 6'd25 && (rem > half || (rem == half && q[0]))) begin
        qr = q + 24'd1;
      end
    end
  end

  // Select the result
  always_comb begin
    res_o.range_error = 1'b0;
    if (ex == ExpMax || (ex == '0 && frac == '0)) begin
      res_o.result_bits = op_i.value_bits;
    end else if (under) begin
      res_o.result_bits = {sign, 31'd0};
      res_o.range_error = 1'b1;
    end else if (e > EWidth'(254)) begin
      res_o.result_bits = {sign, 31'd0} | InfBits;
      res_o.range_error = 1'b1;
    end else if (e >= EWidth'(1)) begin
      res_o.result_bits = {sign, e[ExpWidth-1:0], sig[FracWidth-1:0]};
    end else begin
      res_o.result_bits = {sign, 7'd0, qr};
    end
  end

endmodule

[rtl/float32_scale_by_power_of_two.sv]
// float32_scale_by_power_of_two: result = value * 2^power on binary32 patterns.
// Input channel op carries value_bits and a signed 16-bit power; output
// channel res carries result_bits and range_error (overflow to infinity or
// explicit underflow to zero). Both are valid/ready; an item moves on a
// clock edge with valid and ready high.
// Structure: one input register, one pass of combinational logic, one result
// register; an accepted item enters the result register once that register
// is empty or its item is being taken.
// Throughput: one item per cycle while the receiver keeps ready high; the
// single-pass datapath between the two registers sets this.
// When the receiver stalls, the result register holds its item and the
// input register holds the next one; the input side stays ready while its
// register is empty or the stage ahead of it can move.
// Reset clears both valid flags; no item is in flight afterward.
module float32_scale_by_power_of_two (
  input  logic clk_i,
  input  logic rst_ni,
  fsp2_op_if.sink    op_i,
  fsp2_res_if.source res_o
);
  import fsp2_pkg::*;

  op_t  in_q;
  logic in_vld_q;
  res_t out_q;
  logic out_vld_q;
  res_t calc;
  logic out_adv;
  logic in_adv;

  fsp2_core u_core (.op_i(in_q), .res_o(calc));

  assign out_adv     = !out_vld_q || res_o.ready;
  assign in_adv      = !in_vld_q || out_adv;
  assign op_i.ready  = in_adv;
  assign res_o.valid = out_vld_q;
  assign res_o.data  = out_q;

  // Advance control flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (out_adv) out_vld_q <= in_vld_q;
      if (in_adv)  in_vld_q  <= op_i.valid;
    end
  end

  // Hold payloads
  always_ff @(posedge clk_i) begin
    if (out_adv && in_vld_q) out_q <= calc;
    if (in_adv && op_i.valid) in_q <= op_i.data;
  end

endmodule

[tb/float32_scale_by_power_of_two_tb.sv]
`timescale 1ns / 100ps

module float32_scale_by_power_of_two_tb;
  import fsp2_pkg::*;

  localparam int unsigned NumRandom = 1530;
  localparam int unsigned Latency   = 4;

  // Directed row: operand, power, and an optional typed-in expectation
  typedef struct {
    logic [31:0] value_bits;
    logic [15:0] power;
    bit          has_exp;
    logic [31:0] exp_bits;
    logic        exp_rerr;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  fsp2_op_if  op_if ();
  fsp2_res_if res_if ();

  float32_scale_by_power_of_two uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .op_i   (op_if.sink),
    .res_o  (res_if.source)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  res_t scaled_q[$];
  int   fail_cnt = 0;
  bit   quiet_rx = 1'b0;

  // Round right by sh with ties to even
  function automatic logic [31:0] round_shift(logic [31:0] sig, int sh);
    logic [31:0] q;
    logic [31:0] rem;
    logic [31:0] half;
    if (sh > 30) return 32'd0;
    q    = sig >> sh;
    rem  = sig & ((32'd1 << sh) - 32'd1);
    half = 32'd1 << (sh - 1);
    if (rem > half || (rem == half && q[0])) q = q + 32'd1;
    return q;
  endfunction

  // Predict value times two to power
  function automatic res_t scale_pow2(logic [31:0] v, logic signed [15:0] pw);
    res_t r;
    logic [31:0] sgn;
    int ex;
    int e;
    int k;
    int p;
    logic [31:0] sig;
    bit under;
    p   = int'(pw);
    sgn = v & 32'h8000_0000;
    ex  = int'(v[30:23]);
    r.range_error = 1'b0;
    if (ex == 255 || (ex == 0 && v[22:0] == 23'd0)) begin
      r.result_bits = v;
      return r;
    end
    if (ex != 0) begin
      sig   = {8'd0, 1'b1, v[22:0]};
      e     = ex + p;
      under = (e < -23);
    end else begin
      sig = {9'd0, v[22:0]};
      k   = 0;
      while (sig[23] == 1'b0 && k < 24) begin
        sig = sig << 1;
        k++;
      end
      e     = 1 - k + p;
      under = (p < -23);
    end
    if (under) begin
      r.result_bits = sgn;
      r.range_error = 1'b1;
    end else if (e > 254) begin
      r.result_bits = sgn | InfBits;
      r.range_error = 1'b1;
    end else if (e >= 1) begin
      r.result_bits = sgn | (32'(e) << 23) | {9'd0, sig[22:0]};
    end else begin
      r.result_bits = sgn | round_shift(sig, 1 - e);
    end
    return r;
  endfunction

  // Random operand biased toward interesting exponents and sparse fractions
  function automatic logic [31:0] rand_value();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(0, 7))
      0: v[30:23] = 8'd0;
      1: v[30:23] = 8'd255;
      2: v[30:23] = 8'($urandom_range(1, 30));
      3: v[30:23] = 8'($urandom_range(225, 254));
      4: v[22:0] = 23'($urandom_range(0, 3)) << $urandom_range(0, 22);
      default: ;
    endcase
    return v;
  endfunction

  function automatic logic [15:0] rand_power();
    case ($urandom_range(0, 5))
      0: return 16'($urandom);
      1: return 16'($urandom_range(0, 300)) - 16'd150;
      2: return 16'($urandom_range(0, 60)) - 16'd180;
      default: return 16'($urandom_range(0, 80)) - 16'd40;
    endcase
  endfunction

  row_t rows[$];

  task automatic add_row(logic [31:0] v, logic [15:0] p, bit he = 0,
                         logic [31:0] eb = '0, logic er = 1'b0);
    row_t r;
    r.value_bits = v;
    r.power      = p;
    r.has_exp    = he;
    r.exp_bits   = eb;
    r.exp_rerr   = er;
    rows.push_back(r);
  endtask

  // Send one item, with optional idle burst before it
  task automatic send_item(logic [31:0] v, logic [15:0] p, bit may_idle);
    op_t o;
    if (may_idle && $urandom_range(0, 3) == 0) begin
      op_if.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk_i);
    end
    o.value_bits = v;
    o.power      = p;
    op_if.valid <= 1'b1;
    op_if.data  <= o;
    @(posedge clk_i);
    while (!op_if.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Stimulus
  initial begin
    int i;
    res_t ex;
    op_if.valid = 1'b0;
    op_if.data  = '0;
    add_row(32'h0000_0000, 16'sd100, 1, 32'h0000_0000, 1'b0);
    add_row(32'h8000_0000, 16'h8000, 1, 32'h8000_0000, 1'b0);
    add_row(32'h7F80_0000, 16'h8000, 1, 32'h7F80_0000, 1'b0);
    add_row(32'hFF80_0000, 16'h7FFF, 1, 32'hFF80_0000, 1'b0);
    add_row(32'h7FC0_0001, 16'sd5, 1, 32'h7FC0_0001, 1'b0);
    add_row(32'hFFFF_FFFF, 16'hFFFF, 1, 32'hFFFF_FFFF, 1'b0);
    add_row(32'h3F80_0000, 16'h7FFF, 1, 32'h7F80_0000, 1'b1);
    add_row(32'hBF80_0000, 16'h8000, 1, 32'h8000_0000, 1'b1);
    add_row(32'h7F7F_FFFF, 16'sd1, 1, 32'h7F80_0000, 1'b1);
    add_row(32'h0000_0001, 16'hFFE8, 1, 32'h0000_0000, 1'b1);
    add_row(32'h3F80_0000, 16'sd0);
    add_row(32'h3F80_0000, 16'hFF82);
    add_row(32'h3F80_0000, 16'hFF6B);
    add_row(32'h3F80_0000, 16'hFF6A);
    add_row(32'h3FC0_0000, 16'hFF6A);
    add_row(32'h0000_0001, 16'sd23);
    add_row(32'h007F_FFFF, 16'sd1);
    add_row(32'h807F_FFFF, 16'hFFE9);
    add_row(32'h00FF_FFFF, 16'hFFFF);
    add_row(32'h7FFF_FFFF, 16'sd0);
    add_row(32'h0040_0000, 16'sd254);
    add_row(32'h3F7F_FFFF, 16'hFF82);
    add_row(32'h0000_0003, 16'hFFFF);
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    foreach (rows[k]) begin
      if (rows[k].has_exp) begin
        ex.result_bits = rows[k].exp_bits;
        ex.range_error = rows[k].exp_rerr;
      end else begin
        ex = scale_pow2(rows[k].value_bits, rows[k].power);
      end
      scaled_q.push_back(ex);
      send_item(rows[k].value_bits, rows[k].power, 1'b1);
    end
    for (i = 0; i < NumRandom; i++) begin
      logic [31:0] v;
      logic [15:0] p;
      // Hold off once until the pipeline drains
      if (i == NumRandom / 2) begin
        op_if.valid <= 1'b0;
        while (scaled_q.size() != 0) @(negedge clk_i);
      end
      if (i == NumRandom - 200) quiet_rx = 1'b1;
      v = rand_value();
      p = rand_power();
      scaled_q.push_back(scale_pow2(v, p));
      send_item(v, p, i < NumRandom - 200);
    end
    op_if.valid <= 1'b0;
    while (scaled_q.size() != 0) @(negedge clk_i);
    repeat (Latency) @(negedge clk_i);
    if (fail_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Receiver ready with random stall bursts, always ready in the quiet phase
  initial begin
    int stall;
    res_if.ready = 1'b0;
    stall = 0;
    forever begin
      @(negedge clk_i);
      if (quiet_rx) begin
        res_if.ready <= 1'b1;
      end else if (stall > 0) begin
        stall--;
        res_if.ready <= 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 15) - 1;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // Compare each result with the oldest expectation
  always @(posedge clk_i) begin
    res_t exp_r;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (scaled_q.size() == 0) begin
        $error("result_bits: unexpected item, actual %h", res_if.data.result_bits);
        fail_cnt++;
      end else begin
        exp_r = scaled_q.pop_front();
        if (res_if.data.result_bits !== exp_r.result_bits) begin
          $error("result_bits: expected %h actual %h", exp_r.result_bits,
                 res_if.data.result_bits);
          fail_cnt++;
        end
        if (res_if.data.range_error !== exp_r.range_error) begin
          $error("range_error: expected %b actual %b", exp_r.range_error,
                 res_if.data.range_error);
          fail_cnt++;
        end
      end
    end
  end

  // Timeout
  initial begin
    #1000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
